>>> sv/mcaw_pkg.sv
// Shared types and constants for the Monte Carlo acceptance weight pipeline.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mcaw_pkg;

   // Input field: energy difference, two's complement with DIFF_FRAC_BITS fraction bits
   localparam int unsigned DIFF_W         = 16;
   localparam int unsigned DIFF_FRAC_BITS = 8;
   localparam int unsigned MAG_W          = DIFF_W;

   // Internal Q32 arithmetic
   localparam int unsigned Q_FRAC  = 32;
   localparam int unsigned X_SHIFT = Q_FRAC - DIFF_FRAC_BITS;
   localparam int unsigned X_W     = MAG_W + X_SHIFT;
   localparam int unsigned E_W     = Q_FRAC + 1;

   localparam logic [Q_FRAC-1:0] LN2_Q32 = 32'hB17217F8;
   localparam logic [E_W-1:0]    ONE_Q32 = {1'b1, {Q_FRAC{1'b0}}};

   // Range reduction: n = floor(x / ln2), estimated by a reciprocal and corrected once
   localparam longint unsigned N_MAX       = (64'd1 << (X_W - 1)) / 64'hB17217F8;
   localparam int unsigned     N_W         = $clog2(N_MAX + 2);
   localparam int unsigned     RECIP_SHIFT = 32;
   localparam longint unsigned RECIP       = (64'd1 << (X_SHIFT + RECIP_SHIFT)) / 64'hB17217F8;
   localparam int unsigned     RECIP_W     = $clog2(RECIP + 1);

   localparam int unsigned TAYLOR_TERMS = 13;

   // weight_mode register codes
   localparam int unsigned MODE_W          = 2;
   localparam logic [1:0]  MODE_BARKER     = 2'd0;
   localparam logic [1:0]  MODE_MINVAR     = 2'd1;
   localparam logic [1:0]  MODE_METROPOLIS = 2'd2;

   // Control travelling alongside the data in every stage
   typedef struct packed {
      logic valid;
      logic neg;
   } ctl_type;

endpackage

`default_nettype wire

>>> sv/mcaw_range_reduce.sv
// Range reduction of |dE| into n and r with x = n*ln2 + r, five register stages.
// Depends on mcaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcaw_range_reduce (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic signed [mcaw_pkg::DIFF_W-1:0] energy_diff,
   output mcaw_pkg::ctl_type                       out_ctl,
   output logic [mcaw_pkg::Q_FRAC-1:0]             out_r,
   output logic [mcaw_pkg::N_W-1:0]                out_n
);

   localparam int unsigned MAG_W  = mcaw_pkg::MAG_W;
   localparam int unsigned N_W    = mcaw_pkg::N_W;
   localparam int unsigned X_W    = mcaw_pkg::X_W;
   localparam int unsigned Q_FRAC = mcaw_pkg::Q_FRAC;
   localparam int unsigned P_W    = MAG_W + mcaw_pkg::RECIP_W;

   // stage 1: sign and magnitude
   mcaw_pkg::ctl_type s1_ctl_in, s1_ctl_ff;
   logic [MAG_W-1:0]  raw;
   logic [MAG_W-1:0]  s1_mag_in, s1_mag_ff;

   // stage 2: reciprocal estimate of n
   mcaw_pkg::ctl_type s2_ctl_ff;
   logic [P_W-1:0]    nprod;
   logic [N_W-1:0]    s2_nest_in, s2_nest_ff;
   logic [MAG_W-1:0]  s2_mag_ff;

   // stage 3: n_est * ln2
   mcaw_pkg::ctl_type s3_ctl_ff;
   logic [X_W-1:0]    s3_lprod_in, s3_lprod_ff;
   logic [N_W-1:0]    s3_nest_ff;
   logic [MAG_W-1:0]  s3_mag_ff;

   // stage 4: first remainder, below twice ln2
   mcaw_pkg::ctl_type s4_ctl_ff;
   logic [X_W-1:0]    xval;
   logic [X_W-1:0]    rdiff;
   logic [Q_FRAC:0]   s4_r0_in, s4_r0_ff;
   logic [N_W-1:0]    s4_nest_ff;

   // stage 5: single correction step
   mcaw_pkg::ctl_type s5_ctl_ff;
   logic [Q_FRAC:0]   rsub;
   logic [Q_FRAC-1:0] s5_r_in, s5_r_ff;
   logic [N_W-1:0]    s5_n_in, s5_n_ff;

   assign raw             = unsigned'(energy_diff);
   assign s1_ctl_in.valid = in_valid;
   assign s1_ctl_in.neg   = raw[MAG_W-1];
   assign s1_mag_in       = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;

   assign nprod       = P_W'(s1_mag_ff) * P_W'(mcaw_pkg::RECIP);
   assign s2_nest_in  = nprod[mcaw_pkg::RECIP_SHIFT +: N_W];

   assign s3_lprod_in = X_W'(s2_nest_ff) * X_W'(mcaw_pkg::LN2_Q32);

   assign xval     = {s3_mag_ff, {mcaw_pkg::X_SHIFT{1'b0}}};
   assign rdiff    = xval - s3_lprod_ff;
   assign s4_r0_in = rdiff[Q_FRAC:0];

   assign rsub = s4_r0_ff - {1'b0, mcaw_pkg::LN2_Q32};

   always_comb begin
      if (s4_r0_ff >= {1'b0, mcaw_pkg::LN2_Q32}) begin
         s5_r_in = rsub[Q_FRAC-1:0];
         s5_n_in = s4_nest_ff + N_W'(1);
      end else begin
         s5_r_in = s4_r0_ff[Q_FRAC-1:0];
         s5_n_in = s4_nest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
         s3_ctl_ff.valid <= 1'b0;
         s4_ctl_ff.valid <= 1'b0;
         s5_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff   <= s1_mag_in;
         s2_mag_ff   <= s1_mag_ff;
         s2_nest_ff  <= s2_nest_in;
         s3_mag_ff   <= s2_mag_ff;
         s3_nest_ff  <= s2_nest_ff;
         s3_lprod_ff <= s3_lprod_in;
         s4_nest_ff  <= s3_nest_ff;
         s4_r0_ff    <= s4_r0_in;
         s5_r_ff     <= s5_r_in;
         s5_n_ff     <= s5_n_in;
      end
   end

   assign out_ctl = s5_ctl_ff;
   assign out_r   = s5_r_ff;
   assign out_n   = s5_n_ff;

endmodule

`default_nettype wire

>>> sv/mcaw_exp_series.sv
// exp(-r) by a pipelined Taylor series, two stages a term, then the 2^-n shift.
// Depends on mcaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcaw_exp_series (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire mcaw_pkg::ctl_type           in_ctl,
   input  wire logic [mcaw_pkg::Q_FRAC-1:0] in_r,
   input  wire logic [mcaw_pkg::N_W-1:0]    in_n,
   output mcaw_pkg::ctl_type                out_ctl,
   output logic [mcaw_pkg::E_W-1:0]         out_e
);

   localparam int unsigned TERMS = mcaw_pkg::TAYLOR_TERMS;
   localparam int unsigned N_W   = mcaw_pkg::N_W;
   localparam int unsigned E_W   = mcaw_pkg::E_W;
   localparam bit          SUB_LAST = (TERMS % 2) == 1;

   typedef struct packed {
      logic [31:0]       term;
      logic [E_W-1:0]    sum;
      logic [31:0]       r;
      logic [N_W-1:0]    n;
      mcaw_pkg::ctl_type ctl;
   } ser_type;

   ser_type src   [1:TERMS];
   ser_type pa_ff [2:TERMS];
   ser_type tb_ff [2:TERMS];

   // first term is r itself
   assign src[1].term = in_r;
   assign src[1].sum  = mcaw_pkg::ONE_Q32;
   assign src[1].r    = in_r;
   assign src[1].n    = in_n;
   assign src[1].ctl  = in_ctl;

   for (genvar K = 2; K <= TERMS; K++) begin : g_term
      localparam int unsigned L        = $clog2(K);
      localparam int unsigned S        = 32 + L;
      localparam logic [32:0] M        = 33'(((64'd1 << S) + K - 1) / K);
      localparam bit          SUB_PREV = ((K - 1) % 2) == 1;

      logic [63:0] tr_prod;
      logic [71:0] tm_prod;
      ser_type     pa_in;
      ser_type     tb_in;

      // multiply previous term by r, fold previous term into the sum
      always_comb begin
         pa_in      = src[K-1];
         tr_prod    = 64'(src[K-1].term) * 64'(src[K-1].r);
         pa_in.term = tr_prod[63:32];
         if (SUB_PREV) begin
            pa_in.sum = src[K-1].sum - E_W'(src[K-1].term);
         end else begin
            pa_in.sum = src[K-1].sum + E_W'(src[K-1].term);
         end
      end

      // floor(p / K) by an exact reciprocal
      always_comb begin
         tb_in      = pa_ff[K];
         tm_prod    = 72'(pa_ff[K].term) * 72'(M);
         tb_in.term = tm_prod[S +: 32];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pa_ff[K].ctl.valid <= 1'b0;
            tb_ff[K].ctl.valid <= 1'b0;
         end else if (en) begin
            pa_ff[K] <= pa_in;
            tb_ff[K] <= tb_in;
         end
      end

      assign src[K] = tb_ff[K];
   end

   // fold in the last term
   mcaw_pkg::ctl_type fin_ctl_ff;
   logic [E_W-1:0]    fin_sum_in, fin_sum_ff;
   logic [N_W-1:0]    fin_n_ff;

   // e = sum >> n, zero once n reaches 64
   mcaw_pkg::ctl_type sh_ctl_ff;
   logic              big;
   logic [5:0]        sh_amt;
   logic [E_W-1:0]    sh_e_in, sh_e_ff;

   always_comb begin
      if (SUB_LAST) begin
         fin_sum_in = src[TERMS].sum - E_W'(src[TERMS].term);
      end else begin
         fin_sum_in = src[TERMS].sum + E_W'(src[TERMS].term);
      end
   end

   if (N_W > 6) begin : g_wide_n
      assign big    = |fin_n_ff[N_W-1:6];
      assign sh_amt = fin_n_ff[5:0];
   end else begin : g_narrow_n
      assign big    = 1'b0;
      assign sh_amt = 6'(fin_n_ff);
   end

   assign sh_e_in = big ? '0 : (fin_sum_ff >> sh_amt);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ctl_ff.valid <= 1'b0;
         sh_ctl_ff.valid  <= 1'b0;
      end else if (en) begin
         fin_ctl_ff <= src[TERMS].ctl;
         sh_ctl_ff  <= fin_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_sum_ff <= fin_sum_in;
         fin_n_ff   <= src[TERMS].n;
         sh_e_ff    <= sh_e_in;
      end
   end

   assign out_ctl = sh_ctl_ff;
   assign out_e   = sh_e_ff;

endmodule

`default_nettype wire

>>> sv/mcaw_weight_div.sv
// Barker quotient num/(1+e) by a restoring divider, one quotient bit a stage,
// with the Metropolis weight carried alongside. Depends on mcaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcaw_weight_div #(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire mcaw_pkg::ctl_type        in_ctl,
   input  wire logic [mcaw_pkg::E_W-1:0] in_e,
   output mcaw_pkg::ctl_type             out_ctl,
   output logic [WEIGHT_FRAC_BITS+1:0]   out_q,
   output logic [WEIGHT_FRAC_BITS:0]     out_met
);

   localparam int unsigned W     = WEIGHT_FRAC_BITS;
   localparam int unsigned E_W   = mcaw_pkg::E_W;
   localparam int unsigned DEN_W = E_W + 1;
   localparam int unsigned STEPS = W + 2;
   localparam logic [W:0]  ONE_W = {1'b1, {W{1'b0}}};

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [W+1:0]      q;
      logic [W:0]        met;
      mcaw_pkg::ctl_type ctl;
   } div_type;

   div_type    setup_in;
   div_type    src   [0:STEPS];
   div_type    st_ff [0:STEPS-1];
   logic [W:0] met_e;

   // Metropolis weight: e rounded half up to W fraction bits
   if (W >= 32) begin : g_met_full
      assign met_e = (W+1)'(in_e);
   end else begin : g_met_round
      logic [E_W:0] rnd;
      assign rnd   = {1'b0, in_e} + ((E_W+1)'(1) << (31 - W));
      assign met_e = rnd[32-W +: W+1];
   end

   always_comb begin
      setup_in.den = DEN_W'(mcaw_pkg::ONE_Q32) + DEN_W'(in_e);
      setup_in.rem = in_ctl.neg ? DEN_W'(mcaw_pkg::ONE_Q32) : DEN_W'(in_e);
      setup_in.q   = '0;
      setup_in.met = in_ctl.neg ? ONE_W : met_e;
      setup_in.ctl = in_ctl;
   end

   div_type setup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.ctl.valid <= 1'b0;
      end else if (en) begin
         setup_ff <= setup_in;
      end
   end

   assign src[0] = setup_ff;

   for (genvar I = 0; I < STEPS; I++) begin : g_step
      logic [DEN_W-1:0] shifted;
      logic             take;
      div_type          st_in;

      // first step compares without shifting
      assign shifted = (I == 0) ? src[I].rem : (src[I].rem << 1);
      assign take    = shifted >= src[I].den;

      always_comb begin
         st_in     = src[I];
         st_in.rem = take ? (shifted - src[I].den) : shifted;
         st_in.q   = {src[I].q[W:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[I].ctl.valid <= 1'b0;
         end else if (en) begin
            st_ff[I] <= st_in;
         end
      end

      assign src[I+1] = st_ff[I];
   end

   assign out_ctl = src[STEPS].ctl;
   assign out_q   = src[STEPS].q;
   assign out_met = src[STEPS].met;

endmodule

`default_nettype wire

>>> sv/mc_acceptance_weight.sv
// Depth: 35 + WEIGHT_FRAC_BITS register stages (51 by default). Throughput: one item
// per cycle while the rsp channel is not stalled; the Taylor series takes two stages per
// term and the divider one quotient bit per stage, so the depth follows those two units.
// A stalled rsp channel freezes every stage at once; req_tready falls with it.
// Reset (synchronous, active high) clears all valid bits and sets weight_mode to Barker.
`timescale 1ns / 1ps
`default_nettype none

module mc_acceptance_weight #(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request channel
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   input  wire logic [15:0]                               req_tdata,  // [15:0] energy_diff
   // response channel
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // [W:0] accept_weight, [W+1] mode_error, zero padding above (W = WEIGHT_FRAC_BITS)
   output logic [((WEIGHT_FRAC_BITS + 9) / 8) * 8 - 1:0]  rsp_tdata,
   // configuration: weight_mode
   input  wire logic                                      csr_wr_en,
   input  wire logic [1:0]                                csr_wr_data
);

   localparam int unsigned W     = WEIGHT_FRAC_BITS;
   localparam int unsigned RSP_W = ((WEIGHT_FRAC_BITS + 9) / 8) * 8;
   localparam logic [W:0]  ONE_W = {1'b1, {W{1'b0}}};

   // ---------------------------------------------------------------------------------
   // Mode register. The user must change it only while the pipeline is empty; the block
   // does not enforce it, and the output stage reads it directly instead of piping it.
   // ---------------------------------------------------------------------------------
   logic [mcaw_pkg::MODE_W-1:0] weight_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_mode_ff <= mcaw_pkg::MODE_BARKER;
      end else if (csr_wr_en) begin
         weight_mode_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------------------
   // Global advance: every stage moves together whenever the output register is empty
   // or its item is being taken. Valid bits ride with the data, so bubbles pass through
   // harmlessly and a stall neither drops nor repeats an item.
   // ---------------------------------------------------------------------------------
   logic rsp_tvalid_ff;
   logic en;

   assign en         = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = en;

   logic signed [mcaw_pkg::DIFF_W-1:0] energy_diff;
   assign energy_diff = signed'(req_tdata);

   // range reduction: |dE| -> n, r
   mcaw_pkg::ctl_type              rr_ctl;
   logic [mcaw_pkg::Q_FRAC-1:0]    rr_r;
   logic [mcaw_pkg::N_W-1:0]       rr_n;

   mcaw_range_reduce u_range (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .energy_diff (energy_diff),
      .out_ctl     (rr_ctl),
      .out_r       (rr_r),
      .out_n       (rr_n)
   );

   // e = exp(-|dE|) in Q32
   mcaw_pkg::ctl_type              ex_ctl;
   logic [mcaw_pkg::E_W-1:0]       ex_e;

   mcaw_exp_series u_exp (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (rr_ctl),
      .in_r    (rr_r),
      .in_n    (rr_n),
      .out_ctl (ex_ctl),
      .out_e   (ex_e)
   );

   // Barker quotient and Metropolis weight
   mcaw_pkg::ctl_type div_ctl;
   logic [W+1:0]      div_q;
   logic [W:0]        div_met;

   mcaw_weight_div #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (ex_ctl),
      .in_e    (ex_e),
      .out_ctl (div_ctl),
      .out_q   (div_q),
      .out_met (div_met)
   );

   // ---------------------------------------------------------------------------------
   // Output stage: round the quotient half up, select by mode, hold until taken.
   // ---------------------------------------------------------------------------------
   logic [W+1:0]     q_round;
   logic [W:0]       weight;
   logic             mode_error;
   logic [RSP_W-1:0] rsp_tdata_in, rsp_tdata_ff;

   assign q_round = div_q + (W+2)'(1);

   always_comb begin
      unique case (weight_mode_ff)
         mcaw_pkg::MODE_BARKER, mcaw_pkg::MODE_MINVAR: begin
            weight     = q_round[W+1:1];
            mode_error = 1'b0;
         end
         mcaw_pkg::MODE_METROPOLIS: begin
            weight     = div_met;
            mode_error = 1'b0;
         end
         default: begin
            // unknown mode: flag it and drop the weight to zero
            weight     = '0;
            mode_error = 1'b1;
         end
      endcase
   end

   assign rsp_tdata_in = RSP_W'({mode_error, weight});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= div_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------
   a_error_zero_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[W+1] |-> rsp_tdata_ff[W:0] == '0)
      else $error("mode error delivered with a non-zero weight");

   a_weight_at_most_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_tdata_ff[W:0] <= ONE_W)
      else $error("acceptance weight above 1.0");

   a_bubble_reaches_output: assert property (@(posedge clock) disable iff (reset)
      en && !div_ctl.valid |=> !rsp_tvalid_ff)
      else $error("output valid without an item from the divider");

endmodule

`default_nettype wire

>>> tb/mcaw_weight_checker.sv
// Scoreboard for mc_acceptance_weight: predicts one weight per accepted request item.
// It compares each response field by field and counts failures for the top.
// Depends on mcaw_pkg for widths, Q32 constants and weight_mode codes.
`timescale 1ns / 1ps

module mcaw_weight_checker #(
   parameter int unsigned W = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [15:0] energy_diff
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [W:0] accept_weight, [W+1] mode_error, zero padding above
   input  logic [((W + 9) / 8) * 8 - 1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_wr_data,
   output int                                 fail_count,
   output int                                 outstanding
);

   localparam int unsigned DIFF_W = mcaw_pkg::DIFF_W;
   localparam int unsigned MODE_W = mcaw_pkg::MODE_W;

   typedef struct packed {
      logic [DIFF_W-1:0] diff;
      logic              err;
      logic [W:0]        weight;
   } outcome_type;

   outcome_type       weights_due[$];
   logic [MODE_W-1:0] mode_shadow = mcaw_pkg::MODE_BARKER;
   int                failures = 0;

   // exp(-x) in Q32 for x >= 0: range reduction by ln 2, then a 13-term Taylor sum
   function automatic logic [63:0] decay_q32(input logic [63:0] x);
      logic [63:0] ln2, n, r, term, sum;
      int          k;
      ln2  = {32'd0, mcaw_pkg::LN2_Q32};
      n    = x / ln2;
      r    = x - n * ln2;
      term = 64'(mcaw_pkg::ONE_Q32);
      sum  = term;
      for (k = 1; k <= mcaw_pkg::TAYLOR_TERMS; k++) begin
         term = ((term * r) >> 32) / 64'(k);
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      if (n >= 64) return 64'd0;
      return sum >> n;
   endfunction

   // num/den scaled to W fraction bits by restoring division, rounded half up
   function automatic logic [63:0] ratio_round(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem, q;
      int          i;
      rem = num;
      q   = 64'd0;
      if (rem >= den) begin
         q   = 64'd1;
         rem = rem - den;
      end
      for (i = 0; i < W + 1; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= den) begin
            q[0] = 1'b1;
            rem  = rem - den;
         end
      end
      return (q + 64'd1) >> 1;
   endfunction

   function automatic logic [63:0] round_to_w(input logic [63:0] e);
      if (W >= 32) return e;
      return (e + (64'd1 << (31 - W))) >> (32 - W);
   endfunction

   function automatic outcome_type acceptance_weight(input logic [DIFF_W-1:0] diff,
                                                     input logic [MODE_W-1:0] mode);
      logic        neg;
      logic [63:0] mag, e, one_q, scaled;
      outcome_type res;
      neg   = diff[DIFF_W-1];
      mag   = neg ? (64'd1 << DIFF_W) - 64'(diff) : 64'(diff);
      e     = decay_q32(mag << mcaw_pkg::X_SHIFT);
      one_q = 64'(mcaw_pkg::ONE_Q32);
      res   = '0;
      res.diff = diff;
      case (mode)
         mcaw_pkg::MODE_BARKER, mcaw_pkg::MODE_MINVAR: begin
            scaled = ratio_round(neg ? one_q : e, one_q + e);
         end
         mcaw_pkg::MODE_METROPOLIS: begin
            scaled = neg ? (64'd1 << W) : round_to_w(e);
         end
         default: begin
            scaled  = 64'd0;
            res.err = 1'b1;
         end
      endcase
      res.weight = scaled[W:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type want;
      logic [W:0]  got_weight;
      logic        got_err;
      logic        pad_bad;
      if (reset) begin
         mode_shadow = mcaw_pkg::MODE_BARKER;
         weights_due.delete();
      end else begin
         if (csr_wr_en) mode_shadow = csr_wr_data;
         if (req_tvalid && req_tready)
            weights_due.push_back(acceptance_weight(req_tdata, mode_shadow));
         if (rsp_tvalid && rsp_tready) begin
            got_weight = rsp_tdata[W:0];
            got_err    = rsp_tdata[W+1];
            pad_bad    = (rsp_tdata >> (W + 2)) != 0;
            if (weights_due.size() == 0) begin
               if (failures < 10)
                  $display("unexpected response: weight %0d error %0b", got_weight, got_err);
               failures++;
            end else begin
               want = weights_due.pop_front();
               if (got_weight !== want.weight || got_err !== want.err || pad_bad) begin
                  if (failures < 10)
                     $display({"mismatch dE=%h: weight exp %0d got %0d, ",
                               "error exp %0b got %0b, pad %h"},
                              want.diff, want.weight, got_weight, want.err, got_err,
                              rsp_tdata >> (W + 2));
                  failures++;
               end
            end
         end
      end
      outstanding <= weights_due.size();
      fail_count  <= failures;
   end

endmodule

>>> tb/tb_mc_acceptance_weight.sv
// Top of the mc_acceptance_weight testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on mcaw_pkg, the block itself and mcaw_weight_checker, which does all prediction.
`timescale 1ns / 1ps

module tb_mc_acceptance_weight;

   localparam int unsigned       DIFF_W           = mcaw_pkg::DIFF_W;
   localparam int unsigned       MODE_W           = mcaw_pkg::MODE_W;
   localparam int unsigned       WEIGHT_FRAC_BITS = 16;
   localparam int unsigned       RSP_W            = ((WEIGHT_FRAC_BITS + 9) / 8) * 8;
   // the block rejects this code with mode_error; the package names only the valid ones
   localparam logic [MODE_W-1:0] MODE_UNKNOWN     = 2'd3;
   localparam int                PHASES           = 8;
   localparam int                PHASE_ITEMS      = 210;
   // pipeline depth is 35 + WEIGHT_FRAC_BITS; leave a margin after the last response
   localparam int                SETTLE_CYCLES    = 35 + WEIGHT_FRAC_BITS + 16;
   // worst case is roughly 1700 items, each with its longest gap and stall, plus a full
   // pipeline per drain; the limit allows several times that
   localparam int                CYCLE_LIMIT      = 200000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DIFF_W-1:0] req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wr_en   = 1'b0;
   logic [1:0]        csr_wr_data = mcaw_pkg::MODE_BARKER;

   int                fail_count;
   int                pending;
   // when set, both sides run flat out with no gaps or stalls
   bit                calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mc_acceptance_weight #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mcaw_weight_checker #(
      .W (WEIGHT_FRAC_BITS)
   ) weight_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (pending)
   );

   // Offer one item, after a random gap unless calm, and hold it until accepted.
   // On return tvalid is still high, so a following item can go straight out.
   task automatic push_diff(input logic [DIFF_W-1:0] diff);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= diff;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait for every predicted weight to come back.
   // The first edge lets the checker record the item accepted on the previous one.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write weight_mode only with the pipeline empty.
   task automatic set_mode(input logic [MODE_W-1:0] mode);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Bias towards magnitudes where the weight is neither saturated nor underflowed;
   // keep a share of fully random words so every bit toggles.
   function automatic logic [DIFF_W-1:0] pick_diff();
      logic [DIFF_W-1:0] mag;
      case ($urandom_range(0, 9))
         0, 1: mag = DIFF_W'($urandom_range(0, 63));
         2, 3, 4: mag = DIFF_W'($urandom_range(0, 16'h0C00));
         5: begin
            // extremes and the point where the exponent shift reaches 64
            case ($urandom_range(0, 5))
               0: return 16'h0000;
               1: return 16'h7FFF;
               2: return 16'h8000;
               3: return 16'h8001;
               4: mag = 16'h2C5C;
               default: mag = 16'h2C5D;
            endcase
         end
         default: return DIFF_W'($urandom);
      endcase
      return ($urandom_range(0, 1) == 1) ? -mag : mag;
   endfunction

   // Receiver: draw a stall per item, then hold tready until a response is taken.
   initial begin : receiver
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [MODE_W-1:0] mode;
      int                p;
      int                i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Barker straight out of reset: zero gives one half, saturation at both ends,
      // underflow either side of the exponent-shift limit
      push_diff(16'h0000);
      push_diff(16'h0001);
      push_diff(16'hFFFF);
      push_diff(16'h0100);
      push_diff(16'hFF00);
      push_diff(16'h00B1);
      push_diff(16'h0B17);
      push_diff(16'h2C5C);
      push_diff(16'h2C5D);
      push_diff(16'h7FFF);
      push_diff(16'h8000);
      push_diff(16'h8001);

      // Metropolis: negative dE gives exactly one, zero gives one, tail rounding to zero
      set_mode(mcaw_pkg::MODE_METROPOLIS);
      push_diff(16'h0000);
      push_diff(16'h8000);
      push_diff(16'hFFFF);
      push_diff(16'h0001);
      push_diff(16'h0100);
      push_diff(16'h0B17);
      push_diff(16'h0B18);
      push_diff(16'h7FFF);

      // unknown mode: error flag with zero weight
      set_mode(MODE_UNKNOWN);
      push_diff(16'h0000);
      push_diff(16'h7FFF);
      push_diff(16'h8000);

      // random phases: every mode in turn, then modes drawn at random
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: mode = mcaw_pkg::MODE_MINVAR;
            1: mode = mcaw_pkg::MODE_METROPOLIS;
            2: mode = mcaw_pkg::MODE_BARKER;
            3: mode = MODE_UNKNOWN;
            default: mode = MODE_W'($urandom_range(0, 3));
         endcase
         set_mode(mode);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // a quarter of the stretches run with no idling at all
            if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            // on odd phases, hold off mid-phase until the pipeline has emptied
            if (i == PHASE_ITEMS / 2 && p % 2 == 1) drain_results();
            push_diff(pick_diff());
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog: fail the run once CYCLE_LIMIT is reached, so handshakes that stop making progress cannot hang it.
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
sv/mcaw_pkg.sv
sv/mcaw_range_reduce.sv
sv/mcaw_exp_series.sv
sv/mcaw_weight_div.sv
sv/mc_acceptance_weight.sv
tb/mcaw_weight_checker.sv
tb/tb_mc_acceptance_weight.sv
